>>> hw/rtl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg: shared types and constants for the axis-angle rotation block
// Holds the CORDIC arctangent table, fixed-point constants and the
// payload structs carried by the stream interfaces.
// ----------------------------------------------------------------------------
package aarm_pkg;

  localparam int TABLE_LEN = 24;

  // CORDIC datapath width: Q.30 values with headroom
  localparam int CW = 34;

  localparam logic signed [CW-1:0] Q30_ONE      = 34'sd1073741824;
  localparam logic signed [CW-1:0] Q30_PI       = 34'sd3373259426;
  localparam logic signed [CW-1:0] Q30_HALF_PI  = 34'sd1686629713;
  localparam logic signed [CW-1:0] Q30_INV_GAIN = 34'sd652032874;

  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_item_t;

  // Item state carried down the CORDIC pipeline
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               flip;
    cval_t              x;
    cval_t              y;
    cval_t              z;
  } cstage_t;

  // Arctangent of 2^-i, Q.30, rounded to nearest
  function automatic cval_t atan_q30(input logic [4:0] i);
    cval_t r;
    unique case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/aarm_in_if.sv
// ----------------------------------------------------------------------------
// aarm_in_if: request stream interface
// Valid/ready channel carrying one axis and angle per transaction.
// ----------------------------------------------------------------------------
interface aarm_in_if;
  logic               valid;
  logic               ready;
  aarm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/aarm_out_if.sv
// ----------------------------------------------------------------------------
// aarm_out_if: result stream interface
// Valid/ready channel carrying nine matrix entries per transaction.
// ----------------------------------------------------------------------------
interface aarm_out_if;
  logic                valid;
  logic                ready;
  aarm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/aarm_cordic_step.sv
// ----------------------------------------------------------------------------
// aarm_cordic_step: one registered CORDIC rotation stage
// Rotates x/y by atan(2^-STEP) towards z = 0 and registers the result.
// ----------------------------------------------------------------------------
module aarm_cordic_step #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_in,
  input  aarm_pkg::cstage_t st_in,
  output logic              vld_out,
  output aarm_pkg::cstage_t st_out
);
  import aarm_pkg::*;

  localparam logic [4:0] IDX = 5'(STEP);

  logic    vld_r;
  cstage_t st_r;
  cstage_t st_nxt;
  cval_t   dx;
  cval_t   dy;
  cval_t   ang;

  // Rotate one step; arithmetic shift rounds towards minus infinity
  always_comb begin
    dx  = st_in.y >>> STEP;
    dy  = st_in.x >>> STEP;
    ang = atan_q30(IDX);
    st_nxt = st_in;
    if (!st_in.z[CW-1]) begin
      st_nxt.x = st_in.x - dx;
      st_nxt.y = st_in.y + dy;
      st_nxt.z = st_in.z - ang;
    end else begin
      st_nxt.x = st_in.x + dx;
      st_nxt.y = st_in.y - dy;
      st_nxt.z = st_in.z + ang;
    end
  end

  // Advance when the pipeline moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
endmodule

>>> hw/rtl/aarm_matrix.sv
// ----------------------------------------------------------------------------
// aarm_matrix: Rodrigues entry pipeline
// From c, s and the axis, forms the nine Q1.14 entries over three
// registered stages: products, weighted terms, sums with rounding.
// ----------------------------------------------------------------------------
module aarm_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  aarm_pkg::cstage_t   st_in,
  output logic                vld_out,
  output aarm_pkg::out_item_t res_out
);
  import aarm_pkg::*;

  typedef logic signed [31:0] p32_t;
  typedef logic signed [67:0] q58_t;

  // Stage A: c, s, axis products
  logic  [2:0]  vld_r;
  cval_t        c_r, s_r, omc_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  p32_t  pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r;

  // Stage B: weighted terms
  q58_t  cq_r, txx_r, tyy_r, tzz_r, txy_r, txz_r, tyz_r, sx_r, sy_r, sz_r;

  // Stage C: rounded entries
  out_item_t res_r;

  cval_t c_nxt, s_nxt;

  always_comb begin
    c_nxt = st_in.flip ? -st_in.x : st_in.x;
    s_nxt = st_in.flip ? -st_in.y : st_in.y;
  end

  function automatic logic signed [15:0] finish(input q58_t v);
    q58_t r;
    r = (v + (q58_t'(1) <<< 43)) >>> 44;
    if (r > 68'sd32767)       return 16'sh7fff;
    else if (r < -68'sd32768) return 16'sh8000;
    else                      return r[15:0];
  endfunction

  // Hold valid bits down the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r   <= c_nxt;
      s_r   <= s_nxt;
      omc_r <= Q30_ONE - c_nxt;
      ax_r  <= st_in.ax;
      ay_r  <= st_in.ay;
      az_r  <= st_in.az;
      pxx_r <= p32_t'(st_in.ax) * p32_t'(st_in.ax);
      pyy_r <= p32_t'(st_in.ay) * p32_t'(st_in.ay);
      pzz_r <= p32_t'(st_in.az) * p32_t'(st_in.az);
      pxy_r <= p32_t'(st_in.ax) * p32_t'(st_in.ay);
      pxz_r <= p32_t'(st_in.ax) * p32_t'(st_in.az);
      pyz_r <= p32_t'(st_in.ay) * p32_t'(st_in.az);

      cq_r  <= q58_t'(c_r) <<< 28;
      txx_r <= q58_t'(omc_r) * q58_t'(pxx_r);
      tyy_r <= q58_t'(omc_r) * q58_t'(pyy_r);
      tzz_r <= q58_t'(omc_r) * q58_t'(pzz_r);
      txy_r <= q58_t'(omc_r) * q58_t'(pxy_r);
      txz_r <= q58_t'(omc_r) * q58_t'(pxz_r);
      tyz_r <= q58_t'(omc_r) * q58_t'(pyz_r);
      sx_r  <= (q58_t'(s_r) * q58_t'(ax_r)) <<< 14;
      sy_r  <= (q58_t'(s_r) * q58_t'(ay_r)) <<< 14;
      sz_r  <= (q58_t'(s_r) * q58_t'(az_r)) <<< 14;

      res_r.m00 <= finish(cq_r + txx_r);
      res_r.m01 <= finish(txy_r - sz_r);
      res_r.m02 <= finish(txz_r + sy_r);
      res_r.m10 <= finish(txy_r + sz_r);
      res_r.m11 <= finish(cq_r + tyy_r);
      res_r.m12 <= finish(tyz_r - sx_r);
      res_r.m20 <= finish(txz_r - sy_r);
      res_r.m21 <= finish(tyz_r + sx_r);
      res_r.m22 <= finish(cq_r + tzz_r);
    end
  end

  assign vld_out = vld_r[2];
  assign res_out = res_r;
endmodule

>>> hw/rtl/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: Rodrigues rotation block from axis and angle
//
//   channel | dir | payload                          | handshake
//   in      | in  | axis_x, axis_y, axis_z, angle    | valid/ready
//   out     | out | m00 .. m22 (Q1.14, saturated)    | valid/ready
//
// One transaction per cycle while the output is not stalled. The stages are
// one quadrant stage, one register per CORDIC step, three matrix stages and
// the output register. Synchronous active-low reset clears valid bits only.
// The whole pipeline holds while the output is full and not taken.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  aarm_in_if.sink    in_ch,
  aarm_out_if.source out_ch
);
  import aarm_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  logic en;
  logic vld_r;
  cstage_t st_r, st_nxt;
  logic    [NSTEP:0] cv;
  cstage_t cs [NSTEP+1];
  logic      mvld;
  out_item_t mres;
  logic      ovld_r;
  out_item_t ores_r;

  // Advance when the output register is empty or being drained
  assign en = !ovld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Fold the angle into a quarter turn
  always_comb begin
    cval_t z;
    z = cval_t'(in_ch.data.angle) <<< 17;
    st_nxt.ax   = in_ch.data.axis_x;
    st_nxt.ay   = in_ch.data.axis_y;
    st_nxt.az   = in_ch.data.axis_z;
    st_nxt.x    = Q30_INV_GAIN;
    st_nxt.y    = '0;
    st_nxt.flip = 1'b0;
    st_nxt.z    = z;
    if (z > Q30_HALF_PI) begin
      st_nxt.z = z - Q30_PI;
      st_nxt.flip = 1'b1;
    end else if (z < -Q30_HALF_PI) begin
      st_nxt.z = z + Q30_PI;
      st_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign cv[0] = vld_r;
  assign cs[0] = st_r;

  // CORDIC stages
  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    aarm_cordic_step #(.STEP(g)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (cv[g]),
      .st_in   (cs[g]),
      .vld_out (cv[g+1]),
      .st_out  (cs[g+1])
    );
  end

  aarm_matrix u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (cv[NSTEP]),
    .st_in   (cs[NSTEP]),
    .vld_out (mvld),
    .res_out (mres)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= mvld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ores_r <= mres;
    end
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.data  = ores_r;
endmodule
